// ===== sv/xkpc_pkg.sv =====
`timescale 1ns / 1ps
// xkpc_pkg: shared types, register codes and Base64 helpers for the XOR-key cipher.
// No dependencies; used by every module of the block.
package xkpc_pkg;

    localparam int KEY_BYTES_DEF = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int KLEN_W        = 6;
    localparam int GRP_W         = 16;
    localparam int RES_MAX       = 4;
    localparam int RES_CNT_W     = 3;

    localparam logic [KLEN_W-1:0] KLEN_RST = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE    = 3'd0,
        REG_KEY_LEN = 3'd1,
        REG_KEY_W0  = 3'd2,
        REG_KEY_W1  = 3'd3,
        REG_KEY_W2  = 3'd4,
        REG_KEY_W3  = 3'd5
    } cfg_reg_t;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic [7:0] B64_PAD = 8'd61;  // '='

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       last;
    } res_t;

    typedef struct packed {
        res_t [RES_MAX-1:0]   items;
        logic [RES_CNT_W-1:0] n;
    } bundle_t;

    // 6-bit value to character of the standard alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)      return w + 8'd65;
        else if (v < 6'd52) return w + 8'd71;
        else if (v < 6'd62) return w - 8'd4;
        else if (v == 6'd62) return 8'd43;
        else                return 8'd47;
    endfunction

    // character to {valid, value}
    function automatic logic [6:0] b64_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= 8'd65 && c <= 8'd90) begin
            t = c - 8'd65;
            return {1'b1, t[5:0]};
        end else if (c >= 8'd97 && c <= 8'd122) begin
            t = c - 8'd71;
            return {1'b1, t[5:0]};
        end else if (c >= 8'd48 && c <= 8'd57) begin
            t = c + 8'd4;
            return {1'b1, t[5:0]};
        end else if (c == 8'd43) begin
            return {1'b1, 6'd62};
        end else if (c == 8'd47) begin
            return {1'b1, 6'd63};
        end
        return 7'd0;
    endfunction

endpackage

// ===== sv/xor_key_position_cipher_base64_top.sv =====
`timescale 1ns / 1ps
// Channel  | dir | handshake              | payload
// s_       | in  | s_valid / s_ready      | s_in_byte[7:0], s_in_last
// m_       | out | m_valid / m_ready      | m_out_byte[7:0], m_out_has_data, m_out_last
// cfg_     | in  | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[63:0]
//
// A beat is held in the input register; the cipher and Base64 logic then
// turns it into 0, 1 or 4 results in one pass, loaded into the result register.
// The result register drains one result per cycle while m_ready is high; encode
// gives 4 results per 3 bytes, so throughput is set by that port.
// Beats that give no result flow at one per cycle while the result port is free.
// aresetn (synchronous, active low) clears message state and loads config defaults.
// Back-pressure on m_ready holds the result register, then the input register.
//
// Depends on xkpc_pkg, xkpc_cfg, xkpc_core, xkpc_obuf.
module xor_key_position_cipher_base64_top #(
    parameter int KEY_BYTES = xkpc_pkg::KEY_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input beats
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_in_byte,
    input  logic                              s_in_last,
    // result beats
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_out_byte,
    output logic                              m_out_has_data,
    output logic                              m_out_last,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [xkpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [xkpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                        mode;
    logic [xkpc_pkg::KLEN_W-1:0] key_length;
    logic [KEY_BYTES-1:0][7:0]   key_bytes;
    logic                        sink_free;
    logic                        bundle_valid;
    xkpc_pkg::bundle_t           bundle;

    // config registers; the user must write them only between messages, not enforced here
    xkpc_cfg #(
        .KEY_BYTES (KEY_BYTES)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mode       (mode),
        .key_length (key_length),
        .key_bytes  (key_bytes)
    );

    // input register, key/position state, group state and result logic
    xkpc_core #(
        .KEY_BYTES (KEY_BYTES)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_byte      (s_in_byte),
        .in_last      (s_in_last),
        .mode         (mode),
        .key_length   (key_length),
        .key_bytes    (key_bytes),
        .sink_free    (sink_free),
        .bundle_valid (bundle_valid),
        .bundle       (bundle)
    );

    // result register: takes a new bundle as the previous one's last beat leaves
    xkpc_obuf u_obuf (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (bundle_valid),
        .bundle         (bundle),
        .free           (sink_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_out_has_data (m_out_has_data),
        .m_out_last     (m_out_last)
    );

endmodule

// ===== sv/xkpc_cfg.sv =====
`timescale 1ns / 1ps
// xkpc_cfg: configuration registers (mode, key length, key bytes).
// Depends on xkpc_pkg.
module xkpc_cfg #(
    parameter int KEY_BYTES = xkpc_pkg::KEY_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [xkpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [xkpc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              mode,
    output logic [xkpc_pkg::KLEN_W-1:0]       key_length,
    output logic [KEY_BYTES-1:0][7:0]         key_bytes
);

    logic                        mode_reg;
    logic [xkpc_pkg::KLEN_W-1:0] klen_reg;
    logic [7:0]                  key_reg [KEY_BYTES];

    assign cfg_ready  = 1'b1;
    assign mode       = mode_reg;
    assign key_length = klen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= xkpc_pkg::MODE_ENC;
            klen_reg <= xkpc_pkg::KLEN_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                xkpc_pkg::REG_MODE:    mode_reg <= cfg_data[0];
                xkpc_pkg::REG_KEY_LEN: klen_reg <= cfg_data[xkpc_pkg::KLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // byte b sits in key word b/8, lane b%8
    for (genvar b = 0; b < KEY_BYTES; b++) begin : g_key
        localparam int WRD  = b / 8;
        localparam int LANE = (b % 8) * 8;
        localparam logic [xkpc_pkg::CFG_IDX_W-1:0] WIDX =
            xkpc_pkg::CFG_IDX_W'(int'(xkpc_pkg::REG_KEY_W0) + WRD);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                key_reg[b] <= 8'd0;
            end else if (cfg_valid && cfg_index == WIDX) begin
                key_reg[b] <= cfg_data[LANE +: 8];
            end
        end

        assign key_bytes[b] = key_reg[b];
    end

endmodule

// ===== sv/xkpc_core.sv =====
`timescale 1ns / 1ps
// xkpc_core: input register, message state and single-pass cipher/Base64 logic.
// Depends on xkpc_pkg; feeds a result bundle to xkpc_obuf.
module xkpc_core #(
    parameter int KEY_BYTES = xkpc_pkg::KEY_BYTES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  in_byte,
    input  logic                        in_last,
    input  logic                        mode,
    input  logic [xkpc_pkg::KLEN_W-1:0] key_length,
    input  logic [KEY_BYTES-1:0][7:0]   key_bytes,
    input  logic                        sink_free,
    output logic                        bundle_valid,
    output xkpc_pkg::bundle_t           bundle
);

    localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam logic [6:0] KB7 = 7'(KEY_BYTES);

    logic                       in_vld_reg, in_vld_next;
    logic [7:0]                 in_byte_reg;
    logic                       in_last_reg;
    logic [KIDX_W-1:0]          kidx_reg, kidx_next, kidx_adv;
    logic [7:0]                 pos_reg, pos_next;
    logic [xkpc_pkg::GRP_W-1:0] bits_reg, bits_next;
    logic [1:0]                 cnt_reg, cnt_next;

    logic                       adv;
    logic [6:0]                 len7, len_eff, nxt7;
    logic [7:0]                 mask, enc, dec_byte;
    logic [6:0]                 val;
    logic [23:0]                grp;
    logic                       has_byte;

    assign adv          = in_vld_reg && sink_free;
    assign in_ready     = !in_vld_reg || adv;
    assign bundle_valid = adv;

    // input register
    always_comb begin
        in_vld_next = in_vld_reg;
        if (in_valid && in_ready) in_vld_next = 1'b1;
        else if (adv)             in_vld_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    // key index advance: clamp length to 1..KEY_BYTES, wrap at it
    always_comb begin
        len7 = {1'b0, key_length};
        if (len7 == 7'd0)     len_eff = 7'd1;
        else if (len7 > KB7)  len_eff = KB7;
        else                  len_eff = len7;
        nxt7     = 7'(kidx_reg) + 7'd1;
        kidx_adv = (nxt7 >= len_eff) ? '0 : nxt7[KIDX_W-1:0];
    end

    always_comb begin
        kidx_next = kidx_reg;
        pos_next  = pos_reg;
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        bundle    = '0;
        mask      = key_bytes[kidx_reg] ^ pos_reg;
        enc       = in_byte_reg ^ mask;
        val       = xkpc_pkg::b64_value(in_byte_reg);
        grp       = 24'd0;
        dec_byte  = 8'd0;
        has_byte  = 1'b0;

        if (mode == xkpc_pkg::MODE_ENC) begin
            kidx_next = kidx_adv;
            pos_next  = pos_reg + 8'd1;
            unique case (cnt_reg)
                2'd0: begin
                    bits_next = {8'd0, enc};
                    cnt_next  = 2'd1;
                end
                2'd1: begin
                    bits_next = {bits_reg[7:0], enc};
                    cnt_next  = 2'd2;
                end
                2'd2, 2'd3: begin
                    grp = {bits_reg, enc};
                    bundle.items[0] = '{data: xkpc_pkg::b64_char(grp[23:18]),
                                        has_data: 1'b1, last: 1'b0};
                    bundle.items[1] = '{data: xkpc_pkg::b64_char(grp[17:12]),
                                        has_data: 1'b1, last: 1'b0};
                    bundle.items[2] = '{data: xkpc_pkg::b64_char(grp[11:6]),
                                        has_data: 1'b1, last: 1'b0};
                    bundle.items[3] = '{data: xkpc_pkg::b64_char(grp[5:0]),
                                        has_data: 1'b1, last: in_last_reg};
                    bundle.n  = 3'd4;
                    bits_next = '0;
                    cnt_next  = 2'd0;
                end
            endcase
            // flush of a partial group with padding
            if (in_last_reg && bundle.n == 3'd0) begin
                if (cnt_next == 2'd1) grp = {bits_next[7:0], 16'd0};
                else                  grp = {bits_next, 8'd0};
                bundle.items[0] = '{data: xkpc_pkg::b64_char(grp[23:18]),
                                    has_data: 1'b1, last: 1'b0};
                bundle.items[1] = '{data: xkpc_pkg::b64_char(grp[17:12]),
                                    has_data: 1'b1, last: 1'b0};
                bundle.items[2] = '{data: (cnt_next == 2'd1) ? xkpc_pkg::B64_PAD
                                          : xkpc_pkg::b64_char(grp[11:6]),
                                    has_data: 1'b1, last: 1'b0};
                bundle.items[3] = '{data: xkpc_pkg::B64_PAD, has_data: 1'b1, last: 1'b1};
                bundle.n = 3'd4;
            end
        end else begin
            if (val[6]) begin
                unique case (cnt_reg)
                    2'd0: begin
                        bits_next = {10'd0, val[5:0]};
                    end
                    2'd1: begin
                        dec_byte  = {bits_reg[5:0], val[5:4]};
                        bits_next = {12'd0, val[3:0]};
                        has_byte  = 1'b1;
                    end
                    2'd2: begin
                        dec_byte  = {bits_reg[3:0], val[5:2]};
                        bits_next = {14'd0, val[1:0]};
                        has_byte  = 1'b1;
                    end
                    2'd3: begin
                        dec_byte  = {bits_reg[1:0], val[5:0]};
                        bits_next = '0;
                        has_byte  = 1'b1;
                    end
                endcase
                cnt_next = cnt_reg + 2'd1;
                if (has_byte) begin
                    kidx_next = kidx_adv;
                    pos_next  = pos_reg + 8'd1;
                    bundle.items[0] = '{data: dec_byte ^ mask, has_data: 1'b1,
                                        last: in_last_reg};
                    bundle.n = 3'd1;
                end
            end
            // end-only marker
            if (in_last_reg && bundle.n == 3'd0) begin
                bundle.items[0] = '{data: 8'd0, has_data: 1'b0, last: 1'b1};
                bundle.n = 3'd1;
            end
        end

        if (in_last_reg) begin
            kidx_next = '0;
            pos_next  = 8'd0;
            bits_next = '0;
            cnt_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kidx_reg <= '0;
            pos_reg  <= 8'd0;
            bits_reg <= '0;
            cnt_reg  <= 2'd0;
        end else if (adv) begin
            kidx_reg <= kidx_next;
            pos_reg  <= pos_next;
            bits_reg <= bits_next;
            cnt_reg  <= cnt_next;
        end
    end

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_last_reg |=> kidx_reg == '0 && pos_reg == 8'd0 &&
                               bits_reg == '0 && cnt_reg == 2'd0)
        else $error("message state not cleared after last beat");

    a_bundle_size: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |-> bundle.n == 3'd0 || bundle.n == 3'd1 || bundle.n == 3'd4)
        else $error("bad result count");

    a_enc_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_last_reg && mode == xkpc_pkg::MODE_ENC
            |-> bundle.n == 3'd4 && bundle.items[3].last)
        else $error("encode did not flush on last beat");

    a_dec_last: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && mode == xkpc_pkg::MODE_DEC |-> bundle.items[0].last == in_last_reg)
        else $error("decode last flag mismatch");

endmodule

// ===== sv/xkpc_obuf.sv =====
`timescale 1ns / 1ps
// xkpc_obuf: result register holding up to four results, drained one per beat.
// Depends on xkpc_pkg; loaded from xkpc_core.
module xkpc_obuf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  xkpc_pkg::bundle_t bundle,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_out_has_data,
    output logic              m_out_last
);

    xkpc_pkg::res_t [xkpc_pkg::RES_MAX-1:0] ent_reg, ent_next;
    logic [xkpc_pkg::RES_CNT_W-1:0]         cnt_reg, cnt_next;
    logic                                   pop;

    assign m_valid        = cnt_reg != '0;
    assign pop            = m_valid && m_ready;
    assign free           = cnt_reg == '0 || (cnt_reg == 3'd1 && m_ready);
    assign m_out_byte     = ent_reg[0].data;
    assign m_out_has_data = ent_reg[0].has_data;
    assign m_out_last     = ent_reg[0].last;

    always_comb begin
        ent_next = ent_reg;
        cnt_next = cnt_reg;
        if (load) begin
            ent_next = bundle.items;
            cnt_next = bundle.n;
        end else if (pop) begin
            for (int i = 0; i < xkpc_pkg::RES_MAX - 1; i++) begin
                ent_next[i] = ent_reg[i+1];
            end
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4)
        else $error("result count overflow");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> cnt_reg == '0 || (cnt_reg == 3'd1 && pop))
        else $error("bundle loaded over pending results");

endmodule

// ===== dv/xor_key_position_cipher_base64_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for xor_key_position_cipher_base64_top: directed and random
// messages in both modes, checked against an in-bench predictor of the cipher.
// Depends on xkpc_pkg and the top level only.
module xor_key_position_cipher_base64_top_test;

    // Drain after the last expected result: a beat in the input register,
    // one pass into the result register, plus margin for bytes that give no result.
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 48;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_beat_t;

    logic                            aclk;
    logic                            aresetn        = 1'b0;
    logic                            s_valid        = 1'b0;
    logic                            s_ready;
    logic [7:0]                      s_in_byte      = '0;
    logic                            s_in_last      = 1'b0;
    logic                            m_valid;
    logic                            m_ready        = 1'b0;
    logic [7:0]                      m_out_byte;
    logic                            m_out_has_data;
    logic                            m_out_last;
    logic                            cfg_valid      = 1'b0;
    logic                            cfg_ready;
    logic [xkpc_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [xkpc_pkg::CFG_DATA_W-1:0] cfg_data       = '0;

    // Standard alphabet, indexed by 6-bit value
    string b64_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Configuration as the block should hold it (reset values)
    logic                        cfg_mode = xkpc_pkg::MODE_ENC;
    logic [xkpc_pkg::KLEN_W-1:0] cfg_klen = xkpc_pkg::KLEN_RST;
    logic [63:0]                 cfg_key [4] = '{64'd0, 64'd0, 64'd0, 64'd0};

    // Message state of the predictor
    logic [4:0]  key_idx  = '0;
    logic [7:0]  pos_low  = '0;
    logic [17:0] grp_bits = '0;
    logic [1:0]  grp_cnt  = '0;

    in_beat_t        tx_beats[$];     // beats waiting for the driver
    xkpc_pkg::res_t  due_results[$];  // predicted results, oldest first

    int unsigned fail_count   = 0;
    int unsigned beats_queued = 0;  // beats that do work (ignored characters excluded)
    bit          idle_on      = 1'b1;
    int          hold_phase   = 0;

    // driver and monitor private state
    int unsigned    src_gap   = 0;
    int unsigned    sink_gap  = 0;
    int unsigned    hold_left = 0;
    int             hold_seen = 0;
    in_beat_t       next_beat;
    xkpc_pkg::res_t want;

    int klen_plan [PHASES] = '{32, 1, 0, 63, 7, 17, 32, 3};

    xor_key_position_cipher_base64_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_in_last      (s_in_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_out_has_data (m_out_has_data),
        .m_out_last     (m_out_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // 6-bit value of a character, 64 when it is not in the alphabet
    function automatic int b64_index(input logic [7:0] c);
        for (int k = 0; k < 64; k++) begin
            if (b64_set[k] == c) return k;
        end
        return 64;
    endfunction

    // Pad byte for the current data byte: key byte XOR position. Steps both on.
    function automatic logic [7:0] next_pad();
        logic [7:0] kb;
        logic [7:0] pad;
        int         span;
        kb   = cfg_key[key_idx[4:3]][{key_idx[2:0], 3'b000} +: 8];
        pad  = kb ^ pos_low;
        // lengths out of range clamp to 1..KEY_BYTES
        span = (cfg_klen == 0) ? 1 :
               (cfg_klen > xkpc_pkg::KEY_BYTES_DEF) ? xkpc_pkg::KEY_BYTES_DEF
                                                     : int'(cfg_klen);
        key_idx = (int'(key_idx) + 1 >= span) ? 5'd0 : key_idx + 5'd1;
        pos_low = pos_low + 8'd1;
        return pad;
    endfunction

    function automatic void push_res(input logic [7:0] d, input logic has, input logic lst);
        xkpc_pkg::res_t r;
        r.data     = d;
        r.has_data = has;
        r.last     = lst;
        due_results.push_back(r);
    endfunction

    // Four characters of a 24-bit group; characters past nchar become '='
    function automatic void emit_group(input logic [23:0] g, input int nchar,
                                       input logic lst);
        logic [7:0] ch;
        for (int k = 0; k < 4; k++) begin
            ch = (k < nchar) ? b64_set[(g >> (18 - 6 * k)) & 24'd63] : xkpc_pkg::B64_PAD;
            push_res(ch, 1'b1, lst && (k == 3));
        end
    endfunction

    // One accepted input beat: advance the predictor and queue its results
    function automatic void cipher_step(input logic [7:0] b, input logic lst);
        logic [7:0]  e;
        logic [31:0] acc;
        int          v;
        int          pend;
        int          rest;
        bit          gave;
        gave = 1'b0;
        if (cfg_mode == xkpc_pkg::MODE_ENC) begin
            e = b ^ next_pad();
            case (grp_cnt)
                2'd0: begin
                    grp_bits = {10'd0, e};
                    grp_cnt  = 2'd1;
                end
                2'd1: begin
                    grp_bits = {2'd0, grp_bits[7:0], e};
                    grp_cnt  = 2'd2;
                end
                default: begin
                    // a count of 3 left by decode is treated as 2
                    emit_group({grp_bits[15:0], e}, 4, lst);
                    grp_bits = '0;
                    grp_cnt  = 2'd0;
                    gave     = 1'b1;
                end
            endcase
            if (lst && !gave) begin
                if (grp_cnt == 2'd1) emit_group({grp_bits[7:0], 16'd0}, 2, 1'b1);
                else                 emit_group({grp_bits[15:0], 8'd0}, 3, 1'b1);
                gave = 1'b1;
            end
        end else begin
            v = b64_index(b);
            if (v < 64) begin
                pend = (grp_cnt == 2'd0) ? 0 : (grp_cnt == 2'd1) ? 6 :
                       (grp_cnt == 2'd2) ? 4 : 2;
                acc  = (({14'd0, grp_bits} & ((32'd1 << pend) - 32'd1)) << 6) | v;
                if (pend >= 2) begin
                    rest     = pend - 2;
                    grp_bits = 18'(acc & ((32'd1 << rest) - 32'd1));
                    push_res(8'(acc >> rest) ^ next_pad(), 1'b1, lst);
                    gave     = 1'b1;
                end else begin
                    grp_bits = 18'(acc);
                end
                grp_cnt = grp_cnt + 2'd1;
            end
            // end of message with no byte: end-only marker, leftover bits dropped
            if (lst && !gave) push_res(8'd0, 1'b0, 1'b1);
        end
        if (lst) begin
            key_idx  = '0;
            pos_low  = '0;
            grp_bits = '0;
            grp_cnt  = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued beats, predicts each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) cipher_step(s_in_byte, s_in_last);
            // valid is only dropped or moved on once the current beat has gone
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 13);  // random burst of idle cycles
                    s_valid <= 1'b0;
                end else if (tx_beats.size() > 0) begin
                    next_beat = tx_beats.pop_front();
                    s_in_byte <= next_beat.data;
                    s_in_last <= next_beat.last;
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result beat, throttles m_ready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result beat: out_byte %02h has_data %0b last %0b",
                           m_out_byte, m_out_has_data, m_out_last);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (m_out_byte !== want.data) begin
                        $error("out_byte: expected %02h, got %02h", want.data, m_out_byte);
                        fail_count++;
                    end
                    if (m_out_has_data !== want.has_data) begin
                        $error("out_has_data: expected %0b, got %0b",
                               want.has_data, m_out_has_data);
                        fail_count++;
                    end
                    if (m_out_last !== want.last) begin
                        $error("out_last: expected %0b, got %0b", want.last, m_out_last);
                        fail_count++;
                    end
                end
            end
            // long hold-off, asked for once per new hold_phase value
            if (hold_phase != hold_seen) begin
                hold_seen = hold_phase;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (called from the sequence below, on falling edges)
    // ------------------------------------------------------------------
    function automatic void add_beat(input logic [7:0] b, input logic lst);
        in_beat_t t;
        t.data = b;
        t.last = lst;
        tx_beats.push_back(t);
        if (cfg_mode == xkpc_pkg::MODE_ENC || b64_index(b) < 64 || lst) beats_queued++;
    endfunction

    // Register write; the shadow copy follows at the accepting edge
    task automatic write_reg(input xkpc_pkg::cfg_reg_t idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            xkpc_pkg::REG_MODE:    cfg_mode   = val[0];
            xkpc_pkg::REG_KEY_LEN: cfg_klen   = val[xkpc_pkg::KLEN_W-1:0];
            xkpc_pkg::REG_KEY_W0:  cfg_key[0] = val;
            xkpc_pkg::REG_KEY_W1:  cfg_key[1] = val;
            xkpc_pkg::REG_KEY_W2:  cfg_key[2] = val;
            xkpc_pkg::REG_KEY_W3:  cfg_key[3] = val;
            default: ;
        endcase
    endtask

    // Wait until every beat has gone in and every result has come out
    task automatic settle();
        @(negedge aclk);
        while (tx_beats.size() != 0 || s_valid || due_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // One message, or its head only when close is clear
    task automatic queue_message(input int len, input bit close);
        int         npad;
        logic [7:0] c;
        if (cfg_mode == xkpc_pkg::MODE_ENC) begin
            for (int i = 0; i < len; i++)
                add_beat(8'($urandom_range(0, 255)), close && (i == len - 1));
        end else begin
            // mostly whole groups, some with '=' padding; the rest ragged
            npad = (len % 4 == 0 && $urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 11) == 0) begin
                    c = ($urandom_range(0, 3) == 0) ? xkpc_pkg::B64_PAD
                                                    : 8'($urandom_range(0, 255));
                    add_beat(c, 1'b0);
                end
                c = (i >= len - npad) ? xkpc_pkg::B64_PAD : b64_set[$urandom_range(0, 63)];
                add_beat(c, close && (i == len - 1));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int start;
        int len;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, reset settings (encode, zero key): full group ending the
        // message, one-byte and two-byte tails, field extremes
        add_beat(8'h00, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(8'h5A, 1'b1);
        add_beat(8'hFF, 1'b1);
        add_beat(8'h00, 1'b0);
        add_beat(8'h80, 1'b1);
        add_beat(8'h3C, 1'b0);  // left open across the mode change
        settle();

        // Decode: group bits from encode read under the new mode
        write_reg(xkpc_pkg::REG_MODE, 64'(xkpc_pkg::MODE_DEC));
        write_reg(xkpc_pkg::REG_KEY_LEN, 64'd5);
        write_reg(xkpc_pkg::REG_KEY_W0, {$urandom, $urandom});
        @(negedge aclk);
        add_beat("g", 1'b1);
        // every character class, skipped characters, end with no byte
        for (int k = 0; k < 64; k++) begin
            if (k % 9 == 0 || k >= 62) add_beat(b64_set[k], 1'b0);
        end
        add_beat(xkpc_pkg::B64_PAD, 1'b0);
        add_beat(8'h00, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat("*", 1'b1);
        add_beat("Q", 1'b1);  // lone character: bits dropped, end-only marker
        add_beat("Q", 1'b0);
        add_beat("W", 1'b0);
        settle();

        // Encode with two decode characters pending: group completes on this byte
        write_reg(xkpc_pkg::REG_MODE, 64'(xkpc_pkg::MODE_ENC));
        @(negedge aclk);
        add_beat(8'hA5, 1'b1);
        settle();

        // Random phases: new settings each time, some messages cut across phases
        for (int ph = 0; ph < PHASES; ph++) begin
            idle_on = !(ph == 3 || ph >= PHASES - 2);
            write_reg(xkpc_pkg::REG_MODE, 64'(ph[0] ^ ph[1]));
            write_reg(xkpc_pkg::REG_KEY_LEN, 64'(klen_plan[ph]));
            write_reg(xkpc_pkg::REG_KEY_W0,
                      (ph == 0) ? '1 : (ph == 3) ? '0 : {$urandom, $urandom});
            write_reg(xkpc_pkg::REG_KEY_W1,
                      (ph == 0) ? '1 : (ph == 3) ? '0 : {$urandom, $urandom});
            write_reg(xkpc_pkg::REG_KEY_W2,
                      (ph == 0) ? '1 : (ph == 3) ? '0 : {$urandom, $urandom});
            write_reg(xkpc_pkg::REG_KEY_W3,
                      (ph == 0) ? '1 : (ph == 3) ? '0 : {$urandom, $urandom});
            @(negedge aclk);
            // receiver holds off while the sender keeps offering: input must stall
            if (ph == 1 || ph == 4) hold_phase = hold_phase + 1;
            start = beats_queued;
            while (beats_queued - start < PHASE_BEATS) begin
                if (cfg_mode == xkpc_pkg::MODE_ENC) len = $urandom_range(1, 24);
                else if ($urandom_range(0, 3) == 0) len = $urandom_range(1, 23);
                else len = 4 * $urandom_range(1, 6);
                queue_message(len, 1'b1);
            end
            if (ph < PHASES - 1 && $urandom_range(0, 1) == 1)
                queue_message($urandom_range(1, 3), 1'b0);
            settle();
        end

        if (fail_count == 0)
            $display("** xor_key_position_cipher_base64_top: PASSED **");
        else
            $display("** xor_key_position_cipher_base64_top: FAILED **");
        $finish;
    end

    // Watchdog: the slowest correct run ends well before this timeout
    initial begin
        #2_000_000;
        $display("** xor_key_position_cipher_base64_top: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/xkpc_pkg.sv
sv/xkpc_cfg.sv
sv/xkpc_core.sv
sv/xkpc_obuf.sv
sv/xor_key_position_cipher_base64_top.sv
dv/xor_key_position_cipher_base64_top_test.sv
